@@ rtl/core/msa_pkg.sv @@
// Shared types and constants for the Margolus falling-sand block.
// No dependencies; used by the rule logic and the top level.
`timescale 1ns / 1ps

package msa_pkg;

  // Largest supported grid side and the widths that follow from it.
  localparam int GRID_MAX   = 1024;
  localparam int COORD_W    = $clog2(GRID_MAX);
  localparam int PAIR_DEPTH = GRID_MAX / 2;
  localparam int PAIR_AW    = $clog2(PAIR_DEPTH);

  // Field widths of the configuration registers and the stream.
  localparam int SIZE_W   = 11;
  localparam int THRESH_W = 16;
  localparam int RAND_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_THRESHOLD = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [SIZE_W-1:0]   GRID_SIZE_RESET = 11'd256;
  localparam logic [THRESH_W-1:0] THRESH_RESET    = 16'd13107;

  // One cell, and the four cells of a 2x2 block (top-left, top-right,
  // bottom-left, bottom-right).
  typedef logic [1:0] cell_t;
  typedef cell_t [3:0] quad_t;

  localparam cell_t CELL_EMPTY = 2'd0;
  localparam cell_t CELL_SAND  = 2'd1;
  localparam cell_t CELL_WALL  = 2'd2;

endpackage

@@ rtl/core/msa_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies; holds the stored top rows of the sand blocks.
`timescale 1ns / 1ps

module msa_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/msa_rules.sv @@
// Update rules for one 2x2 block of the falling-sand automaton.
// Depends on msa_pkg for the cell and block types.
`timescale 1ns / 1ps

module msa_rules (
  input  msa_pkg::quad_t                    quad_i,
  input  logic [msa_pkg::RAND_W-1:0]        rand_i,
  input  logic [msa_pkg::THRESH_W-1:0]      thresh_i,
  output msa_pkg::quad_t                    quad_o
);

  logic tl, tr, bl, br;
  logic no_wall;

  // Occupancy of each cell; any code from wall up blocks all movement.
  assign tl = (quad_i[0] != msa_pkg::CELL_EMPTY);
  assign tr = (quad_i[1] != msa_pkg::CELL_EMPTY);
  assign bl = (quad_i[2] != msa_pkg::CELL_EMPTY);
  assign br = (quad_i[3] != msa_pkg::CELL_EMPTY);
  assign no_wall = (quad_i[0] < msa_pkg::CELL_WALL) && (quad_i[1] < msa_pkg::CELL_WALL) &&
                   (quad_i[2] < msa_pkg::CELL_WALL) && (quad_i[3] < msa_pkg::CELL_WALL);

  // First matching rule wins.
  always_comb begin
    quad_o = quad_i;
    if (no_wall) begin
      if (tl && !tr && !bl && !br) begin
        // Lone top-left grain falls.
        quad_o[0] = msa_pkg::CELL_EMPTY;
        quad_o[2] = msa_pkg::CELL_SAND;
      end else if (!tl && tr && !bl && !br) begin
        // Lone top-right grain falls.
        quad_o[1] = msa_pkg::CELL_EMPTY;
        quad_o[3] = msa_pkg::CELL_SAND;
      end else if ((tl && !tr && bl && !br) || (!tl && tr && !bl && br) ||
                   (!tl && tr && bl && !br) || (tl && !tr && !bl && br)) begin
        // Two grains on a side or a diagonal settle on the bottom row.
        quad_o = {msa_pkg::CELL_SAND, msa_pkg::CELL_SAND,
                  msa_pkg::CELL_EMPTY, msa_pkg::CELL_EMPTY};
      end else if (tl && tr && !bl && br) begin
        // Top-left slides down beside the bottom-right grain.
        quad_o[0] = msa_pkg::CELL_EMPTY;
        quad_o[2] = msa_pkg::CELL_SAND;
      end else if (tl && tr && bl && !br) begin
        // Top-right slides down beside the bottom-left grain.
        quad_o[1] = msa_pkg::CELL_EMPTY;
        quad_o[3] = msa_pkg::CELL_SAND;
      end else if (tl && tr && !bl && !br) begin
        // A top pair over an empty row drops only on a random draw.
        if (rand_i > thresh_i) begin
          quad_o = {msa_pkg::CELL_SAND, msa_pkg::CELL_SAND,
                    msa_pkg::CELL_EMPTY, msa_pkg::CELL_EMPTY};
        end
      end
    end
  end

endmodule

@@ rtl/core/margolus_sand_automaton.sv @@
// Top level of the Margolus falling-sand block: counters, block store and output group.
// Depends on msa_pkg, msa_ram and msa_rules.
`timescale 1ns / 1ps

// Cells stream in raster order, one transaction per cycle at most, and are grouped into
// 2x2 blocks whose origin alternates between 0 and 1 from frame to frame. Cells of a
// block's top row produce no result; they are written in pairs into a block-row RAM.
// The bottom-left cell is held in a register, and the bottom-right cell reads the pair
// back from the registered RAM port, applies the sand rules and emits the four cells
// of the block, top row first. Cells outside every block come out unchanged. An input
// is accepted every cycle except while stalled as below; the output carries one result
// per cycle while out_ready_i is high, so a block's four cells leave one by one from
// the single output group register, and the input stalls only while that group and the
// stage behind it are full. The RAM needs no clearing pass.
// Configuration writes are accepted in every cycle and should be made while idle.
module margolus_sand_automaton (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write channel.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [msa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [msa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Cell input channel.
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     cell_in_i,
  input  logic [msa_pkg::RAND_W-1:0]     random_value_i,
  // Result channel.
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [msa_pkg::COORD_W-1:0]    out_col_o,
  output logic [msa_pkg::COORD_W-1:0]    out_row_o,
  output logic [1:0]                     cell_out_o,
  output logic                           last_o
);

  localparam int CW = msa_pkg::COORD_W;

  // Configuration registers.
  logic [msa_pkg::SIZE_W-1:0]   grid_size_q;
  logic [msa_pkg::THRESH_W-1:0] thresh_q;

  // Raster position and frame parity.
  logic [CW-1:0] col_q, col_d;
  logic [CW-1:0] row_q, row_d;
  logic          offset_q, offset_d;

  // Held cells of the block in progress.
  msa_pkg::cell_t top_left_q;
  msa_pkg::cell_t held_left_q;

  // Stage one: an item that produces results.
  logic                       s1_valid_q;
  logic                       s1_block_q;
  logic [CW-1:0]              s1_col_q;
  logic [CW-1:0]              s1_row_q;
  msa_pkg::cell_t             s1_cell_q;
  msa_pkg::cell_t             s1_left_q;
  logic [msa_pkg::RAND_W-1:0] s1_rand_q;

  // Output group: one result, or the four cells of a block.
  logic           g_valid_q;
  logic           g_block_q;
  logic [1:0]     g_idx_q;
  logic [CW-1:0]  g_col_q;
  logic [CW-1:0]  g_row_q;
  msa_pkg::quad_t g_quad_q;

  logic [msa_pkg::SIZE_W-1:0] size_eff;
  logic [CW-1:0]              size_m1;
  logic [CW-1:0]              c, r;
  logic                       top, bottom, left, right;
  logic [CW-1:0]              pair_diff;
  logic [msa_pkg::PAIR_AW-1:0] pair_idx;
  logic                       in_fire, s1_move, g_done, out_fire;
  logic                       ram_we, ram_re;
  logic [3:0]                 ram_wdata, ram_rdata;
  msa_pkg::quad_t             blk_quad, new_quad;

  assign cfg_ready_o = 1'b1;

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= msa_pkg::GRID_SIZE_RESET;
      thresh_q    <= msa_pkg::THRESH_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        msa_pkg::REG_GRID_SIZE:      grid_size_q <= cfg_data_i[msa_pkg::SIZE_W-1:0];
        msa_pkg::REG_DROP_THRESHOLD: thresh_q    <= cfg_data_i[msa_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective grid side, clamped to the supported range.
  always_comb begin
    if (grid_size_q < msa_pkg::SIZE_W'(2)) begin
      size_eff = msa_pkg::SIZE_W'(2);
    end else if (grid_size_q > msa_pkg::SIZE_W'(msa_pkg::GRID_MAX)) begin
      size_eff = msa_pkg::SIZE_W'(msa_pkg::GRID_MAX);
    end else begin
      size_eff = grid_size_q;
    end
  end
  assign size_m1 = CW'(size_eff - msa_pkg::SIZE_W'(1));

  // Saturated position and its place in the block grid.
  assign c = (col_q > size_m1) ? size_m1 : col_q;
  assign r = (row_q > size_m1) ? size_m1 : row_q;

  assign top    = (r >= CW'(offset_q)) && (r[0] == offset_q) && (r < size_m1);
  assign bottom = (r > CW'(offset_q)) && (r[0] != offset_q);
  assign left   = (c >= CW'(offset_q)) && (c[0] == offset_q) && (c < size_m1);
  assign right  = (c > CW'(offset_q)) && (c[0] != offset_q);

  // Both cells of a block column pair share one RAM word.
  assign pair_diff = c - CW'(offset_q);
  assign pair_idx  = pair_diff[CW-1:1];

  // Handshake between the stages.
  assign out_fire   = out_valid_o && out_ready_i;
  assign g_done     = out_fire && last_o;
  assign s1_move    = s1_valid_q && (!g_valid_q || g_done);
  assign in_ready_o = !s1_valid_q || s1_move;
  assign in_fire    = in_valid_i && in_ready_o;

  // Top-right completes the stored pair; bottom-right fetches it back.
  assign ram_we    = in_fire && top && right;
  assign ram_wdata = {cell_in_i, top_left_q};
  assign ram_re    = in_fire && bottom && right;

  msa_ram #(
    .WIDTH (4),
    .DEPTH (msa_pkg::PAIR_DEPTH)
  ) u_pair_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pair_idx),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (pair_idx),
    .rdata_o (ram_rdata)
  );

  // Raster counters advance on every accepted cell.
  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    offset_d = offset_q;
    if (in_fire) begin
      if (c >= size_m1) begin
        col_d = '0;
        if (r >= size_m1) begin
          row_d    = '0;
          offset_d = ~offset_q;
        end else begin
          row_d = r + CW'(1);
        end
      end else begin
        col_d = c + CW'(1);
        row_d = r;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      offset_q    <= 1'b1;
      held_left_q <= msa_pkg::CELL_EMPTY;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      offset_q <= offset_d;
      if (in_fire && !top && bottom && left) begin
        held_left_q <= cell_in_i;
      end
    end
  end

  // Top-left cell waits for its right neighbor before the pair is written.
  always_ff @(posedge clk_i) begin
    if (in_fire && top && left) begin
      top_left_q <= cell_in_i;
    end
  end

  // Stage one captures every cell that produces results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_fire && !(top && (left || right)) && !(bottom && left);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_block_q <= !top && bottom && right;
      s1_col_q   <= c;
      s1_row_q   <= r;
      s1_cell_q  <= cell_in_i;
      s1_left_q  <= held_left_q;
      s1_rand_q  <= random_value_i;
    end
  end

  // Block update from the stored top pair, the held cell and the new cell.
  assign blk_quad = {s1_cell_q, s1_left_q, msa_pkg::cell_t'(ram_rdata[3:2]),
                     msa_pkg::cell_t'(ram_rdata[1:0])};

  msa_rules u_rules (
    .quad_i   (blk_quad),
    .rand_i   (s1_rand_q),
    .thresh_i (thresh_q),
    .quad_o   (new_quad)
  );

  // Output group: loaded from stage one, drained one result per transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_valid_q <= 1'b0;
      g_idx_q   <= '0;
    end else if (s1_move) begin
      g_valid_q <= 1'b1;
      g_idx_q   <= '0;
    end else if (g_done) begin
      g_valid_q <= 1'b0;
      g_idx_q   <= '0;
    end else if (out_fire) begin
      g_idx_q <= g_idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      g_block_q <= s1_block_q;
      if (s1_block_q) begin
        g_col_q  <= s1_col_q - CW'(1);
        g_row_q  <= s1_row_q - CW'(1);
        g_quad_q <= new_quad;
      end else begin
        g_col_q  <= s1_col_q;
        g_row_q  <= s1_row_q;
        g_quad_q <= {msa_pkg::CELL_EMPTY, msa_pkg::CELL_EMPTY, msa_pkg::CELL_EMPTY,
                     s1_cell_q};
      end
    end
  end

  // Result fields of the current position in the group.
  assign out_valid_o = g_valid_q;
  assign out_col_o   = g_col_q + CW'(g_idx_q[0]);
  assign out_row_o   = g_row_q + CW'(g_idx_q[1]);
  assign cell_out_o  = g_quad_q[g_idx_q];
  assign last_o      = g_block_q ? (g_idx_q == 2'd3) : 1'b1;

`ifndef SYNTHESIS
  // A single-cell group never advances past its first result.
  a_pass_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    g_valid_q && !g_block_q |-> g_idx_q == 2'd0)
    else $error("single-cell group advanced past its only result");

  // The block store is never read and written at one entry in the same cycle.
  a_ram_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && ram_re |-> 1'b0)
    else $error("block store read and written in one cycle");

  // A waiting stage-one item is kept until the output group takes it.
  a_s1_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_move |=> s1_valid_q && $stable(s1_col_q) && $stable(s1_row_q))
    else $error("stage-one item lost while stalled");

  // A group that finished its last result is either refilled or empty.
  a_group_refill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    g_done && !s1_move |=> !g_valid_q)
    else $error("output group still valid after its last result");
`endif

endmodule

@@ verif/tb_margolus_sand_automaton.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for margolus_sand_automaton: raster cell streams with random idling,
// back-pressure and register changes, each emitted cell compared with a built-in sand model.
// Depends on msa_pkg and the RTL of the block only.

module tb_margolus_sand_automaton;
  import msa_pkg::*;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 160;
  localparam int TARGET_CELLS  = 315;
  localparam int CALM_CELLS    = 240;

  // Cell code three is not a legal content; the block treats it like a wall.
  localparam cell_t CELL_SPARE = 2'd3;

  // Register indexes past the end of the register list; writes to them are ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    cell_t              content;
    logic               last;
  } emitted_cell_t;

  // Keeps a private copy of the automaton state, predicts the cells that each accepted
  // input releases, and compares the result stream against them in order.
  class sand_scoreboard;
    cell_t               top_row_cells [GRID_MAX];
    cell_t               bottom_left;
    int unsigned         col_cnt;
    int unsigned         row_cnt;
    bit                  origin;
    logic [SIZE_W-1:0]   grid_size;
    logic [THRESH_W-1:0] drop_threshold;
    emitted_cell_t       expected_cells [$];
    int                  errors;

    function new();
      foreach (top_row_cells[i]) top_row_cells[i] = CELL_EMPTY;
      bottom_left    = CELL_EMPTY;
      col_cnt        = 0;
      row_cnt        = 0;
      origin         = 1'b1;
      grid_size      = GRID_SIZE_RESET;
      drop_threshold = THRESH_RESET;
      errors         = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_GRID_SIZE) begin
        grid_size = data[SIZE_W-1:0];
      end else if (idx == REG_DROP_THRESHOLD) begin
        drop_threshold = data[THRESH_W-1:0];
      end
    endfunction

    // Effective grid side after clamping.
    function int unsigned side();
      if (grid_size < 2) return 2;
      if (grid_size > GRID_MAX) return GRID_MAX;
      return 32'(grid_size);
    endfunction

    // True when position p opens a block pair for origin o on a grid of side s.
    function bit pair_start(int unsigned p, int unsigned o, int unsigned s);
      return p >= o && ((p - o) % 2) == 0 && p + 1 <= s - 1;
    endfunction

    // Sand rules for a block without walls; the first matching pattern wins.
    function quad_t settle(quad_t q, logic [RAND_W-1:0] rnd);
      logic [3:0] sand;
      sand = {q[0] != CELL_EMPTY, q[1] != CELL_EMPTY, q[2] != CELL_EMPTY, q[3] != CELL_EMPTY};
      case (sand)
        4'b1000, 4'b1101: begin
          q[0] = CELL_EMPTY;
          q[2] = CELL_SAND;
        end
        4'b0100, 4'b1110: begin
          q[1] = CELL_EMPTY;
          q[3] = CELL_SAND;
        end
        4'b1010, 4'b0101, 4'b0110, 4'b1001: begin
          q[0] = CELL_EMPTY;
          q[1] = CELL_EMPTY;
          q[2] = CELL_SAND;
          q[3] = CELL_SAND;
        end
        4'b1100: begin
          // The top pair drops only when the random value beats the threshold.
          if (rnd > drop_threshold) begin
            q[0] = CELL_EMPTY;
            q[1] = CELL_EMPTY;
            q[2] = CELL_SAND;
            q[3] = CELL_SAND;
          end
        end
        default: ;
      endcase
      return q;
    endfunction

    function void push_expected(int unsigned c, int unsigned r, cell_t v, logic lst);
      emitted_cell_t e;
      e.col     = c[COORD_W-1:0];
      e.row     = r[COORD_W-1:0];
      e.content = v;
      e.last    = lst;
      expected_cells.push_back(e);
    endfunction

    // Advances the model by one accepted input cell.
    function void accept_cell(cell_t v, logic [RAND_W-1:0] rnd);
      int unsigned s, o, c, r;
      bit          top, bottom, left, right;
      quad_t       q;
      s = side();
      o = 32'(origin);
      // Counts past a shrunken edge saturate at the edge.
      c = (col_cnt > s - 1) ? s - 1 : col_cnt;
      r = (row_cnt > s - 1) ? s - 1 : row_cnt;
      top    = pair_start(r, o, s);
      bottom = r >= 1 && pair_start(r - 1, o, s);
      left   = pair_start(c, o, s);
      right  = c >= 1 && pair_start(c - 1, o, s);

      if (top && (left || right)) begin
        top_row_cells[c] = v;
      end else if (bottom && left) begin
        bottom_left = v;
      end else if (bottom && right) begin
        q[0] = top_row_cells[c - 1];
        q[1] = top_row_cells[c];
        q[2] = bottom_left;
        q[3] = v;
        // Any wall or illegal code freezes the whole block.
        if (q[0] < CELL_WALL && q[1] < CELL_WALL && q[2] < CELL_WALL && q[3] < CELL_WALL) begin
          q = settle(q, rnd);
        end
        push_expected(c - 1, r - 1, q[0], 1'b0);
        push_expected(c, r - 1, q[1], 1'b0);
        push_expected(c - 1, r, q[2], 1'b0);
        push_expected(c, r, q[3], 1'b1);
      end else begin
        push_expected(c, r, v, 1'b1);
      end

      // Raster position; the block origin flips at the end of each frame.
      if (c >= s - 1) begin
        col_cnt = 0;
        if (r >= s - 1) begin
          row_cnt = 0;
          origin  = !origin;
        end else begin
          row_cnt = r + 1;
        end
      end else begin
        col_cnt = c + 1;
        row_cnt = r;
      end
    endfunction

    function bit at_frame_start();
      return col_cnt == 0 && row_cnt == 0;
    endfunction

    function int pending();
      return expected_cells.size();
    endfunction

    task report_mismatch(string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      errors++;
    endtask

    task check_cell(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row, cell_t v, logic lst);
      emitted_cell_t e;
      if (expected_cells.size() == 0) begin
        report_mismatch($sformatf("unexpected cell col %0d row %0d content %0d", col, row, v));
        return;
      end
      e = expected_cells.pop_front();
      if (col !== e.col) begin
        report_mismatch($sformatf("column %0d, expected %0d", col, e.col));
      end
      if (row !== e.row) begin
        report_mismatch($sformatf("row %0d, expected %0d", row, e.row));
      end
      if (v !== e.content) begin
        report_mismatch($sformatf("cell (%0d,%0d) content %0d, expected %0d",
                                  e.col, e.row, v, e.content));
      end
      if (lst !== e.last) begin
        report_mismatch($sformatf("cell (%0d,%0d) last %0b, expected %0b",
                                  e.col, e.row, lst, e.last));
      end
    endtask
  endclass

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_valid_i    = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i     = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  cell_t                 cell_in_i      = CELL_EMPTY;
  logic [RAND_W-1:0]     random_value_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  logic [COORD_W-1:0]    out_col_o;
  logic [COORD_W-1:0]    out_row_o;
  cell_t                 cell_out_o;
  logic                  last_o;

  sand_scoreboard sb = new();

  bit          idle_on    = 1'b1;
  int unsigned hold_req   = 0;
  int unsigned hold_done  = 0;
  int unsigned cells_sent = 0;

  margolus_sand_automaton dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cell_in_i      (cell_in_i),
    .random_value_i (random_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_col_o      (out_col_o),
    .out_row_o      (out_row_o),
    .cell_out_o     (cell_out_o),
    .last_o         (last_o)
  );

  // Clock generation.
  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Simulation FAILED");
    $finish;
  end

  // Result side ready: random stall bursts, plus one long hold on request.
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (hold_req != hold_done) begin
        hold_done++;
        stall_left = HOLD_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 17);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Every result transaction is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (out_valid_o === 1'b1 && out_ready_i) begin
      sb.check_cell(out_col_o, out_row_o, cell_out_o, last_o);
    end
  end

  function automatic cell_t rand_cell();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return CELL_EMPTY;
    if (roll < 90) return CELL_SAND;
    if (roll < 97) return CELL_WALL;
    return CELL_SPARE;
  endfunction

  // Random values cluster around the drop threshold now and then.
  function automatic logic [RAND_W-1:0] rand_drop_value();
    case ($urandom_range(0, 7))
      0:       return sb.drop_threshold;
      1:       return sb.drop_threshold + 1'b1;
      default: return RAND_W'($urandom);
    endcase
  endfunction

  // Offers one cell and returns at the falling edge after its transaction.
  task automatic send_cell(cell_t v, logic [RAND_W-1:0] rnd);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cell_in_i      <= v;
    random_value_i <= rnd;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    sb.accept_cell(v, rnd);
    cells_sent++;
    @(negedge clk_i);
  endtask

  // One 2x2 frame on a grid of side two, in raster order.
  task automatic send_quad(cell_t a, cell_t b, cell_t c, cell_t d, logic [RAND_W-1:0] rnd);
    send_cell(a, RAND_W'($urandom));
    send_cell(b, RAND_W'($urandom));
    send_cell(c, RAND_W'($urandom));
    send_cell(d, rnd);
  endtask

  // Random cells up to the next frame boundary.
  task automatic feed_frame();
    do send_cell(rand_cell(), rand_drop_value()); while (!sb.at_frame_start());
  endtask

  // Leaves cfg_valid_i high; the caller lowers it after the last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  // Waits for every predicted cell, then for cells still inside the pipeline.
  task automatic drain();
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic reconfigure(logic [CFG_DATA_W-1:0] grid, logic [CFG_DATA_W-1:0] thr);
    in_valid_i <= 1'b0;
    drain();
    write_reg(REG_GRID_SIZE, grid);
    write_reg(REG_DROP_THRESHOLD, thr);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned            pick, frames;
    logic [CFG_DATA_W-1:0]  grid, thr;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Largest grid: the first row after reset lies outside every block, and writes to
    // indexes past the register list must not disturb anything.
    write_reg(REG_GRID_SIZE, 16'hFFFF);
    write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
    write_reg(REG_DROP_THRESHOLD, 16'hFFFF);
    write_reg(REG_GRID_SIZE, 16'd1024);
    cfg_valid_i <= 1'b0;
    send_cell(CELL_EMPTY, '0);
    send_cell(CELL_SAND, '1);
    send_cell(CELL_WALL, 16'h5555);
    send_cell(CELL_SPARE, 16'hAAAA);
    send_cell(rand_cell(), RAND_W'($urandom));
    send_cell(rand_cell(), RAND_W'($urandom));

    // Shrink in mid-row: the column count saturates at the new edge and ends the row.
    reconfigure(16'd0, 16'hFFFF);
    feed_frame();

    // Top pair over an empty row: equal to the threshold holds, one above it drops.
    reconfigure(16'd2, 16'd0);
    send_quad(CELL_SAND, CELL_SAND, CELL_EMPTY, CELL_EMPTY, 16'd0);
    send_quad(CELL_WALL, CELL_SPARE, CELL_SAND, CELL_EMPTY, '1);
    send_quad(CELL_SAND, CELL_SAND, CELL_EMPTY, CELL_EMPTY, 16'd1);

    // Long receiver hold while cells keep coming, so the block backs up and stalls.
    reconfigure(16'd8, CFG_DATA_W'($urandom));
    idle_on   = 1'b0;
    hold_req++;
    feed_frame();
    feed_frame();
    idle_on = 1'b1;

    // Random phases, mostly small grids so that both block origins recur often.
    while (cells_sent < TARGET_CELLS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        grid = CFG_DATA_W'($urandom_range(0, 1));
      end else if (pick < 3) begin
        grid = CFG_DATA_W'($urandom_range(9, 12));
      end else begin
        grid = CFG_DATA_W'($urandom_range(2, 8));
      end
      case ($urandom_range(0, 4))
        0:       thr = 16'd0;
        1:       thr = 16'hFFFF;
        default: thr = CFG_DATA_W'($urandom);
      endcase
      frames = (grid <= 4) ? 4 : ((grid <= 8) ? 2 : 1);
      reconfigure(grid, thr);
      idle_on = (cells_sent < CALM_CELLS);
      repeat (frames) feed_frame();
    end

    in_valid_i <= 1'b0;
    drain();
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/msa_pkg.sv
rtl/core/msa_ram.sv
rtl/core/msa_rules.sv
rtl/core/margolus_sand_automaton.sv
verif/tb_margolus_sand_automaton.sv
